// File: design/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int POS_WIDTH_DEF   = 16;
  localparam int OUT_POS_WIDTH   = 16;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISS_LEFT  = 2'd1,
    ST_MISS_RIGHT = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t                    status;
    logic [OUT_POS_WIDTH-1:0]   line;
    logic [OUT_POS_WIDTH-1:0]   column;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// File: design/bracket_balance_checker.sv
// Top level of the bracket balance checker: position counters, error latch, result register.
`timescale 1ns / 1ps

// Checks that square brackets in a byte stream pair up. Send one text byte per
// item word; set last on the final byte of a text. Every byte is handled as it
// is accepted: the open-bracket stack is a row of STACK_DEPTH cells that all
// shift by one place in the same cycle on a push or a pop, so a push, a pop and
// the line/column counter updates finish within the cycle the word is accepted.
// The result word for a text sits in an output register from the cycle after
// its last byte; the input keeps taking bytes of the next text while that
// result waits, and stalls only when a result is held and result_ready is low.
// status is ok, missing left bracket (at the stray ']' line and column-1),
// missing right bracket (the innermost unclosed '[', column-1) or stack
// overflow (at the '[' that found the stack full). After the first error the
// rest of the text is ignored. Line and column count from 1 and saturate at
// 2^POS_WIDTH-1; the reported line and column are the low 16 bits. Counters,
// open count and error latch return to their reset values once the result is
// formed (the stack cells keep data). No clearing pass is needed after reset.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int POS_WIDTH   = bbc_pkg::POS_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  bbc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output bbc_pkg::result_t result
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = 2 * POS_WIDTH;

  // state
  logic [CW-1:0]        open_count;
  logic [POS_WIDTH-1:0] line_counter;
  logic [POS_WIDTH-1:0] column_counter;
  bbc_pkg::status_t     error_latched;
  logic [POS_WIDTH-1:0] error_line;
  logic [POS_WIDTH-1:0] error_column;

  logic [CW-1:0]        open_count_next;
  logic [POS_WIDTH-1:0] line_counter_next;
  logic [POS_WIDTH-1:0] column_counter_next;
  bbc_pkg::status_t     error_latched_next;
  logic [POS_WIDTH-1:0] error_line_next;
  logic [POS_WIDTH-1:0] error_column_next;

  logic                 accept;
  logic                 active;
  logic                 is_newline;
  logic                 is_open;
  logic                 is_close;
  logic                 stack_full;
  logic                 stack_empty;
  logic                 hit_overflow;
  logic                 hit_miss_left;
  logic [POS_WIDTH-1:0] line_cur;
  logic [POS_WIDTH-1:0] column_cur;
  logic [POS_WIDTH-1:0] column_inc;
  logic [EW-1:0]        push_data;
  logic [EW-1:0]        stack_top;
  logic [EW-1:0]        stack_second;
  logic [EW-1:0]        top_next;
  bbc_pkg::stack_cmd_t  stack_cmd;
  bbc_pkg::result_t     result_next;

  assign accept     = item_valid && item_ready;
  // a held result only blocks input when the consumer is not taking it
  assign item_ready = !result_valid || result_ready;

  assign active     = (error_latched == bbc_pkg::ST_OK);
  assign is_newline = (item.ch == bbc_pkg::CH_NEWLINE);
  assign is_open    = (item.ch == bbc_pkg::CH_OPEN);
  assign is_close   = (item.ch == bbc_pkg::CH_CLOSE);

  assign stack_full  = (open_count == CW'(STACK_DEPTH));
  assign stack_empty = (open_count == '0);

  assign hit_overflow  = active && is_open && stack_full;
  assign hit_miss_left = active && is_close && stack_empty;

  // newline: bump the line (saturating) and restart the column at 1
  always_comb begin
    line_cur   = line_counter;
    column_cur = column_counter;
    if (is_newline) begin
      line_cur   = (line_counter == '1) ? line_counter : line_counter + 1'b1;
      column_cur = POS_WIDTH'(1);
    end
  end

  assign column_inc = (column_cur == '1) ? column_cur : column_cur + 1'b1;

  assign push_data      = {line_cur, column_cur};
  assign stack_cmd.push = accept && active && is_open && !stack_full;
  assign stack_cmd.pop  = accept && active && is_close && !stack_empty;

  bbc_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .ENTRY_WIDTH(EW)
  ) u_stack (
    .clk      (clk),
    .cmd      (stack_cmd),
    .push_data(push_data),
    .top      (stack_top),
    .second   (stack_second)
  );

  // state after this byte, before any end-of-text clear
  always_comb begin
    open_count_next     = open_count;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    error_latched_next  = error_latched;
    error_line_next     = error_line;
    error_column_next   = error_column;
    if (active) begin
      line_counter_next   = line_cur;
      column_counter_next = column_inc;
      if (stack_cmd.push) begin
        open_count_next = open_count + CW'(1);
      end else if (stack_cmd.pop) begin
        open_count_next = open_count - CW'(1);
      end
      if (hit_overflow || hit_miss_left) begin
        // latch the error and freeze the column where it stood
        error_latched_next  = hit_overflow ? bbc_pkg::ST_OVERFLOW : bbc_pkg::ST_MISS_LEFT;
        error_line_next     = line_cur;
        error_column_next   = column_cur - 1'b1;
        column_counter_next = column_cur;
      end
    end
  end

  // top of stack as it stands after this byte
  always_comb begin
    if (stack_cmd.push) begin
      top_next = push_data;
    end else if (stack_cmd.pop) begin
      top_next = stack_second;
    end else begin
      top_next = stack_top;
    end
  end

  // end-of-text verdict: latched error first, then an unclosed bracket
  always_comb begin
    result_next.status = bbc_pkg::ST_OK;
    result_next.line   = '0;
    result_next.column = '0;
    if (error_latched_next != bbc_pkg::ST_OK) begin
      result_next.status = error_latched_next;
      result_next.line   = bbc_pkg::OUT_POS_WIDTH'(error_line_next);
      result_next.column = bbc_pkg::OUT_POS_WIDTH'(error_column_next);
    end else if (open_count_next != '0) begin
      result_next.status = bbc_pkg::ST_MISS_RIGHT;
      result_next.line   = bbc_pkg::OUT_POS_WIDTH'(top_next[EW-1:POS_WIDTH]);
      result_next.column = bbc_pkg::OUT_POS_WIDTH'(top_next[POS_WIDTH-1:0] - 1'b1);
    end
  end

  // control state: advance on each accepted byte, clear after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      open_count     <= '0;
      line_counter   <= POS_WIDTH'(1);
      column_counter <= POS_WIDTH'(1);
      error_latched  <= bbc_pkg::ST_OK;
      error_line     <= '0;
      error_column   <= '0;
    end else if (accept) begin
      if (item.last) begin
        open_count     <= '0;
        line_counter   <= POS_WIDTH'(1);
        column_counter <= POS_WIDTH'(1);
        error_latched  <= bbc_pkg::ST_OK;
        error_line     <= '0;
        error_column   <= '0;
      end else begin
        open_count     <= open_count_next;
        line_counter   <= line_counter_next;
        column_counter <= column_counter_next;
        error_latched  <= error_latched_next;
        error_line     <= error_line_next;
        error_column   <= error_column_next;
      end
    end
  end

  // result register: load on the last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && item.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last) begin
      result <= result_next;
    end
  end

endmodule

// File: design/bbc_cell.sv
// One stack cell: holds an entry and shifts toward its neighbors on push or pop.
`timescale 1ns / 1ps

module bbc_cell #(
  parameter int ENTRY_WIDTH = 2 * bbc_pkg::POS_WIDTH_DEF
) (
  input  logic                   clk,
  input  bbc_pkg::stack_cmd_t    cmd,
  input  logic [ENTRY_WIDTH-1:0] above,
  input  logic [ENTRY_WIDTH-1:0] below,
  output logic [ENTRY_WIDTH-1:0] entry
);

  // take from the cell above on push, from the cell below on pop, else hold
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      entry <= above;
    end else if (cmd.pop) begin
      entry <= below;
    end
  end

endmodule

// File: design/bbc_stack.sv
// Shift-register stack built as a row of cells; cell 0 is the top of stack.
`timescale 1ns / 1ps

module bbc_stack #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int ENTRY_WIDTH = 2 * bbc_pkg::POS_WIDTH_DEF
) (
  input  logic                   clk,
  input  bbc_pkg::stack_cmd_t    cmd,
  input  logic [ENTRY_WIDTH-1:0] push_data,
  output logic [ENTRY_WIDTH-1:0] top,
  output logic [ENTRY_WIDTH-1:0] second
);

  logic [ENTRY_WIDTH-1:0] cells [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] above;
    logic [ENTRY_WIDTH-1:0] below;

    if (i == 0) begin : g_head
      assign above = push_data;
    end else begin : g_body
      assign above = cells[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = cells[i];
    end else begin : g_inner
      assign below = cells[i+1];
    end

    bbc_cell #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .above(above),
      .below(below),
      .entry(cells[i])
    );
  end

  assign top    = cells[0];
  assign second = cells[1];

endmodule

// File: design/bbc_checker.sv
// Port-level assertions for the bracket balance checker, bound to the top level.
`timescale 1ns / 1ps

module bbc_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input bbc_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input bbc_pkg::result_t result
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed or dropped while stalled");

  // with no result pending the input never stalls
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with no result pending");

  // the last byte of a text always yields a result in the next cycle
  a_last_yields: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last |=> result_valid)
    else $error("no result after last byte");

  // a new result appears only after a last byte
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready && item.last))
    else $error("result without a last byte");

  // an ok verdict carries no position
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == bbc_pkg::ST_OK |-> result.line == '0 && result.column == '0)
    else $error("ok result with nonzero position");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
